### rtl/bntc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bntc_pkg: shared constants and types
// Fixed-point constants, queue item layout and state types for the battery
// ADC and NTC thermistor conversion block.
// ----------------------------------------------------------------------------
package bntc_pkg;

  localparam int ADC_FULL_SCALE = 4095;
  localparam int CODE_W = 16;
  localparam int ADC_W = 12;
  localparam int CFG_W = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] SHORT_THR_RST = 12'd16;
  localparam logic [CFG_W-1:0] OPEN_THR_RST = 12'd4079;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_THRESHOLD = 2'd0,
    CFG_OPEN_THRESHOLD  = 2'd1
  } cfg_reg_t;

  // Voltage scaling: round(code * FS_MV / FULL) = (code * 2 * FS_MV + FULL) / (2 * FULL).
  // The constant divide is a multiply by a rounded-up reciprocal, exact over the code range.
  localparam int VDIV = 2 * ADC_FULL_SCALE;
  localparam int PIN_SCALE = 2 * 3270;
  localparam int CELL_SCALE = 2 * 4905;
  localparam int VACC_W = 26;
  localparam int RECIP_SHIFT = 40;
  localparam logic [63:0] RECIP_M = ((64'd1 << RECIP_SHIFT) + 64'(VDIV) - 64'd1) / 64'(VDIV);
  localparam int PIN_W = 12;
  localparam int CELL_W = 13;

  // Temperature arithmetic.
  localparam int FRAC_W = 24;
  localparam int LOG_W = 28;
  localparam int MANT_W = 32;
  localparam int DIFF_W = LOG_W + 1;
  localparam int LNP_W = 58;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam int DEN_SW = 46;
  localparam logic signed [DEN_SW-1:0] BETA_Q24 = 46'sd395000 <<< FRAC_W;
  localparam logic signed [DEN_SW-1:0] T25_CENTIK = 46'sd29815;
  localparam int NUM_W = 59;
  localparam logic [NUM_W-1:0] TK_NUM = 59'd11776925000 << FRAC_W;
  localparam int DIV_Q_W = 18;
  localparam int DEN_W = 45;
  localparam int TEMP_W = 16;
  localparam logic signed [19:0] ZERO_C_CENTIK = 20'sd27315;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd10000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd30000;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    NTC_NORMAL  = 2'd0,
    NTC_SHORT   = 2'd1,
    NTC_OPEN    = 2'd2,
    NTC_INVALID = 2'd3
  } ntc_state_t;

  typedef struct packed {
    logic [CODE_W-1:0] voltage_code;
    logic [CODE_W-1:0] thermistor_code;
    logic [PIN_W-1:0]  pin_mv;
    logic [CELL_W-1:0] cell_mv;
    logic              voltage_ok;
    ntc_state_t        ntc_state;
    logic [31:0]       now_ms;
  } item_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOG,
    B_LN,
    B_RND,
    B_DEN,
    B_DIVGO,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

### rtl/bntc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bntc_in_if: sample channel
// Valid/ready channel carrying one pair of ADC codes and a timestamp.
// ----------------------------------------------------------------------------
interface bntc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] voltage_code;
  logic [15:0] thermistor_code;
  logic [31:0] now_ms;

  modport source (output valid, output voltage_code, output thermistor_code,
                  output now_ms, input ready);
  modport sink (input valid, input voltage_code, input thermistor_code,
                input now_ms, output ready);
endinterface
`default_nettype wire

### rtl/bntc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bntc_out_if: result channel
// Valid/ready channel carrying one converted measurement.
// ----------------------------------------------------------------------------
interface bntc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_voltage_code;
  logic [15:0] raw_thermistor_code;
  logic [11:0] pin_millivolts;
  logic [12:0] cell_millivolts;
  logic        voltage_ok;
  logic signed [15:0] temperature_centi;
  logic        temperature_ok;
  logic [1:0]  ntc_state;
  logic [31:0] sequence_number;
  logic [31:0] stamp_ms;

  modport source (output valid, output raw_voltage_code, output raw_thermistor_code,
                  output pin_millivolts, output cell_millivolts, output voltage_ok,
                  output temperature_centi, output temperature_ok, output ntc_state,
                  output sequence_number, output stamp_ms, input ready);
  modport sink (input valid, input raw_voltage_code, input raw_thermistor_code,
                input pin_millivolts, input cell_millivolts, input voltage_ok,
                input temperature_centi, input temperature_ok, input ntc_state,
                input sequence_number, input stamp_ms, output ready);
endinterface
`default_nettype wire

### rtl/bntc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bntc_fifo: classified-item queue
// Short queue between the front end and the temperature back end.
// ----------------------------------------------------------------------------
module bntc_fifo import bntc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  link_t push,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t                 slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PTR_W:0]   count_r, count_nxt;
  logic                  do_push, do_pop;

  assign push_ready = (count_r != (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

### rtl/bntc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bntc_front: sample intake and classification
// Holds the thresholds, sorts the NTC code and scales the voltage code.
// ----------------------------------------------------------------------------
module bntc_front import bntc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bntc_in_if.sink              in_ch,
  output link_t                push,
  input  logic                 push_ready,
  output item_t                push_item
);

  logic [CFG_W-1:0]  short_thr_r, open_thr_r;
  logic              s_valid_r, s_valid_nxt;
  item_t             s_item_r;
  logic [VACC_W-1:0] s_apin_r, s_acell_r;
  logic              accept, vok;
  ntc_state_t        st;
  logic [VACC_W-1:0] apin, acell;
  logic [63:0]       pin_prod, cell_prod;

  assign in_ch.ready = !s_valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    vok = (in_ch.voltage_code <= CODE_W'(ADC_FULL_SCALE));
    if (in_ch.thermistor_code > CODE_W'(ADC_FULL_SCALE)) begin
      st = NTC_INVALID;
    end else if (in_ch.thermistor_code <= CODE_W'(short_thr_r)) begin
      st = NTC_SHORT;
    end else if (in_ch.thermistor_code >= CODE_W'(open_thr_r)) begin
      st = NTC_OPEN;
    end else begin
      st = NTC_NORMAL;
    end
    apin  = VACC_W'(in_ch.voltage_code[ADC_W-1:0]) * VACC_W'(PIN_SCALE)
            + VACC_W'(ADC_FULL_SCALE);
    acell = VACC_W'(in_ch.voltage_code[ADC_W-1:0]) * VACC_W'(CELL_SCALE)
            + VACC_W'(ADC_FULL_SCALE);
    s_valid_nxt = accept ? 1'b1 : (push_ready ? 1'b0 : s_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_thr_r <= SHORT_THR_RST;
      open_thr_r  <= OPEN_THR_RST;
      s_valid_r   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_SHORT_THRESHOLD) begin
        short_thr_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_OPEN_THRESHOLD) begin
        open_thr_r <= cfg_data;
      end
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_item_r.voltage_code    <= in_ch.voltage_code;
      s_item_r.thermistor_code <= in_ch.thermistor_code;
      s_item_r.pin_mv          <= '0;
      s_item_r.cell_mv         <= '0;
      s_item_r.voltage_ok      <= vok;
      s_item_r.ntc_state       <= st;
      s_item_r.now_ms          <= in_ch.now_ms;
      s_apin_r                 <= vok ? apin : '0;
      s_acell_r                <= vok ? acell : '0;
    end
  end

  // Reciprocal multiply finishes the rounded constant divide on the way into the queue.
  assign pin_prod  = 64'(s_apin_r) * RECIP_M;
  assign cell_prod = 64'(s_acell_r) * RECIP_M;

  always_comb begin
    push.valid        = s_valid_r;
    push.ready        = push_ready;
    push_item         = s_item_r;
    push_item.pin_mv  = pin_prod[RECIP_SHIFT +: PIN_W];
    push_item.cell_mv = cell_prod[RECIP_SHIFT +: CELL_W];
  end

endmodule
`default_nettype wire

### rtl/bntc_log2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bntc_log2: iterative base-2 logarithm
// Q24 log2 of a 12-bit code, one fraction bit per cycle by mantissa squaring.
// ----------------------------------------------------------------------------
module bntc_log2 import bntc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ADC_W-1:0] val,
  output logic             done,
  output logic [LOG_W-1:0] result
);

  logic [MANT_W-1:0] m_r;
  logic [LOG_W-1:0]  r_r;
  logic [4:0]        cnt_r;
  logic              run_r, done_r;
  logic [3:0]        msb;
  logic [63:0]       sq;
  logic [MANT_W:0]   sq_hi;

  always_comb begin
    msb = '0;
    for (int i = 0; i < ADC_W; i++) begin
      if (val[i]) begin
        msb = 4'(i);
      end
    end
  end

  assign sq    = 64'(m_r) * 64'(m_r);
  assign sq_hi = sq[63:MANT_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && (cnt_r == '0);
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == '0) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r   <= MANT_W'(val) << (5'(MANT_W - 1) - 5'(msb));
      r_r   <= {msb, FRAC_W'(0)};
      cnt_r <= 5'(FRAC_W - 1);
    end else if (run_r) begin
      if (sq_hi[MANT_W]) begin
        r_r <= r_r | (LOG_W'(1) << cnt_r);
        m_r <= sq_hi[MANT_W:1];
      end else begin
        m_r <= sq_hi[MANT_W-1:0];
      end
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign done   = done_r;
  assign result = r_r;

endmodule
`default_nettype wire

### rtl/bntc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bntc_div: restoring divider
// One quotient bit per cycle; the caller guarantees the quotient fits.
// ----------------------------------------------------------------------------
module bntc_div import bntc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic               done,
  output logic [DIV_Q_W-1:0] quo
);

  logic [DEN_W-1:0]   rem_r, den_r;
  logic [DIV_Q_W-1:0] low_r;
  logic [4:0]         cnt_r;
  logic               run_r, done_r;
  logic [DEN_W:0]     trial, diff;
  logic               ge;

  assign trial = {rem_r, low_r[DIV_Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && (cnt_r == '0);
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == '0) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(num >> DIV_Q_W);
      low_r <= num[DIV_Q_W-1:0];
      den_r <= den;
      cnt_r <= 5'(DIV_Q_W - 1);
    end else if (run_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r <= {low_r[DIV_Q_W-2:0], ge};
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign done = done_r;
  assign quo  = low_r;

endmodule
`default_nettype wire

### rtl/bntc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bntc_back: temperature sequencer and result register
// Runs the Beta equation for normal NTC codes and numbers every result.
// ----------------------------------------------------------------------------
module bntc_back import bntc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  pop_valid,
  output logic  pop_ready,
  input  item_t pop_item,
  bntc_out_if.source out_ch
);

  back_state_t state_r, state_nxt;
  item_t       item_r;
  logic signed [DIFF_W-1:0] d_r, ln_r;
  logic [LNP_W-1:0]         lnp_r;
  logic                     neg_r;
  logic signed [DEN_SW-1:0] den_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic                     tok_r;

  logic              out_valid_r, out_valid_nxt;
  item_t             out_item_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic              out_tok_r;
  logic [31:0]       seq_r, seq_nxt;

  logic [ADC_W-1:0]  x_code, n_code;
  logic              pop_normal, pop_edge;
  logic              log_start, div_start, out_load;
  logic              lx_done, ln_done;
  logic [LOG_W-1:0]  lx, lnv;
  logic              div_done;
  logic [DIV_Q_W-1:0] quo;
  logic [LOG_W-1:0]  dmag;
  logic [LNP_W:0]    lnp_rnd;
  logic [LOG_W-1:0]  ln_mag;
  logic [NUM_W-1:0]  div_num;
  logic signed [19:0] tc;

  assign x_code     = pop_item.thermistor_code[ADC_W-1:0];
  assign n_code     = ADC_W'(ADC_FULL_SCALE) - x_code;
  assign pop_normal = (pop_item.ntc_state == NTC_NORMAL);
  assign pop_edge   = (x_code == '0) || (n_code == '0);

  bntc_log2 u_log_x (
    .clk(clk), .rst_n(rst_n), .start(log_start), .val(x_code),
    .done(lx_done), .result(lx)
  );

  bntc_log2 u_log_n (
    .clk(clk), .rst_n(rst_n), .start(log_start), .val(n_code),
    .done(ln_done), .result(lnv)
  );

  assign div_num = TK_NUM + NUM_W'(den_r[DEN_SW-1:1]);

  bntc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(den_r[DEN_W-1:0]), .done(div_done), .quo(quo)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          state_nxt = (pop_normal && !pop_edge) ? B_LOG : B_OUT;
        end
      end
      B_LOG:   if (lx_done) state_nxt = B_LN;
      B_LN:    state_nxt = B_RND;
      B_RND:   state_nxt = B_DEN;
      B_DEN:   state_nxt = B_DIVGO;
      B_DIVGO: state_nxt = (den_r <= 0) ? B_OUT : B_DIV;
      B_DIV:   if (div_done) state_nxt = B_OUT;
      B_OUT:   if (!out_valid_r || out_ch.ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop_ready = 1'b0;
    log_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      B_IDLE: begin
        pop_ready = 1'b1;
        log_start = pop_valid && pop_normal && !pop_edge;
      end
      B_DIVGO: div_start = !(den_r <= 0);
      B_OUT:   out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_comb begin
    dmag    = d_r[DIFF_W-1] ? LOG_W'(-d_r) : LOG_W'(d_r);
    lnp_rnd = (LNP_W+1)'(lnp_r) + ((LNP_W+1)'(1) << 29);
    ln_mag  = lnp_rnd[30 +: LOG_W];
    tc      = $signed({2'b00, quo}) - ZERO_C_CENTIK;
    seq_nxt = seq_r + 32'd1;
    if (seq_nxt == '0) begin
      seq_nxt = 32'd1;
    end
    out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      seq_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (out_load) begin
        seq_r <= seq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && pop_valid) begin
      item_r <= pop_item;
      tok_r  <= pop_normal;
      if (!pop_normal) begin
        temp_r <= '0;
      end else if (x_code == '0) begin
        temp_r <= TEMP_MAX;
      end else begin
        temp_r <= TEMP_MIN;
      end
    end
    if (state_r == B_LOG && lx_done) begin
      d_r <= $signed({1'b0, lx}) - $signed({1'b0, lnv});
    end
    if (state_r == B_LN) begin
      lnp_r <= LNP_W'(dmag) * LNP_W'(LN2_Q30);
      neg_r <= d_r[DIFF_W-1];
    end
    if (state_r == B_RND) begin
      ln_r <= neg_r ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});
    end
    if (state_r == B_DEN) begin
      den_r <= BETA_Q24 + DEN_SW'(ln_r) * T25_CENTIK;
    end
    if (state_r == B_DIVGO && den_r <= 0) begin
      temp_r <= TEMP_MAX;
    end
    if (state_r == B_DIV && div_done) begin
      if (tc < 20'(TEMP_MIN)) begin
        temp_r <= TEMP_MIN;
      end else if (tc > 20'(TEMP_MAX)) begin
        temp_r <= TEMP_MAX;
      end else begin
        temp_r <= TEMP_W'(tc);
      end
    end
    if (out_load) begin
      out_item_r <= item_r;
      out_temp_r <= temp_r;
      out_tok_r  <= tok_r;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.raw_voltage_code    = out_item_r.voltage_code;
  assign out_ch.raw_thermistor_code = out_item_r.thermistor_code;
  assign out_ch.pin_millivolts      = out_item_r.pin_mv;
  assign out_ch.cell_millivolts     = out_item_r.cell_mv;
  assign out_ch.voltage_ok          = out_item_r.voltage_ok;
  assign out_ch.temperature_centi   = out_temp_r;
  assign out_ch.temperature_ok      = out_tok_r;
  assign out_ch.ntc_state           = out_item_r.ntc_state;
  assign out_ch.sequence_number     = seq_r;
  assign out_ch.stamp_ms            = out_item_r.now_ms;

  a_seq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> seq_r != '0)
    else $error("result presented with sequence number zero");

  a_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tok_r |-> out_temp_r == '0)
    else $error("temperature nonzero without a valid conversion");

  a_tok_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tok_r |-> out_item_r.ntc_state == NTC_NORMAL)
    else $error("temperature flagged for a non-normal NTC code");

  a_log_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (lx_done || ln_done) |-> (lx_done && ln_done && state_r == B_LOG))
    else $error("log units finished out of step with the sequencer");

endmodule
`default_nettype wire

### rtl/battery_adc_ntc_sensor_convert_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// battery_adc_ntc_sensor_convert_top: battery voltage and NTC temperature
// Converts ADC code pairs into millivolts and hundredths of a degree C.
// ----------------------------------------------------------------------------
// Usage: a sample transaction on in_ch carries the voltage and NTC codes and
// a millisecond timestamp; exactly one result transaction leaves on out_ch
// for each, in order, numbered by a 32-bit sequence that skips zero.
// The front end registers each sample (voltage scaling by reciprocal
// multiply, NTC classification against the two thresholds) and places it in
// a two-entry queue. The back end works on one item at a time: a normal NTC
// code runs two log2 units side by side (24 squaring steps), the ln and
// denominator states (B_LN, B_RND, B_DEN, B_DIVGO) and an 18-step restoring
// divider; that sequence sets the sustained rate. Non-normal codes pass the
// back end through B_IDLE and B_OUT only. A normal sample passes the front
// register, the queue, the back-end states and the output register.
// When out_ch.ready is low the finished result waits in the output register
// while the back end already starts the next item and the front end keeps
// filling the queue; in_ch.ready falls once the queue and front stage fill.
// Reset (rst_n low, synchronous) empties the queue, clears the sequence
// counter and restores the thresholds to 16 and 4079. Threshold writes on
// cfg_we/cfg_index/cfg_data take effect on the next sample.
// ----------------------------------------------------------------------------
module battery_adc_ntc_sensor_convert_top import bntc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bntc_in_if.sink              in_ch,
  bntc_out_if.source           out_ch
);

  link_t push;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  // Front end: thresholds, classification and voltage scaling.
  bntc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch),
    .push(push), .push_ready(push_ready), .push_item(push_item)
  );

  // Queue decouples intake from the long temperature computation.
  bntc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_ready(push_ready), .push_item(push_item),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item)
  );

  // Back end: Beta equation, sequence numbering and output register.
  bntc_back u_back (
    .clk(clk), .rst_n(rst_n),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item),
    .out_ch(out_ch)
  );

endmodule
`default_nettype wire

### dv/battery_adc_ntc_sensor_convert_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_adc_ntc_sensor_convert_top_test: conversion block testbench
// Drives sample transactions in random bursts, stalls the result channel on
// its own pattern and checks every result field against a fixed-point
// prediction of the voltage scaling, NTC sorting and Beta temperature.
// ----------------------------------------------------------------------------
module battery_adc_ntc_sensor_convert_top_test import bntc_pkg::*; ();

  typedef struct {
    logic [15:0] vcode;
    logic [15:0] tcode;
    logic [31:0] stamp;
  } sample_t;

  typedef struct {
    logic [15:0] vcode;
    logic [15:0] tcode;
    logic [11:0] pin_mv;
    logic [12:0] cell_mv;
    logic        v_ok;
    logic signed [15:0] temp;
    logic        t_ok;
    ntc_state_t  state;
    logic [31:0] seq;
    logic [31:0] stamp;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  bntc_in_if in_ch ();
  bntc_out_if out_ch ();

  battery_adc_ntc_sensor_convert_top i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  // Predictor state: thresholds and the running sequence number.
  logic [11:0] short_thr = 12'd16;
  logic [11:0] open_thr = 12'd4079;
  logic [31:0] seq_count = '0;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int errors = 0;

  // log2 in Q24 from the msb position and 24 steps of mantissa squaring.
  function automatic logic [31:0] log2_fix(input logic [31:0] v);
    logic [31:0] p;
    logic [63:0] m;
    logic [31:0] r;
    p = 0;
    while (p < 31 && (v >> (p + 1)) != 0) p++;
    m = 64'(v) << (31 - p);
    r = p << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        r[i] = 1'b1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic signed [15:0] beta_temp(input int unsigned x, input int unsigned n);
    longint d, ln, den, tk, t;
    longint unsigned mag, num;
    if (x == 0) return 16'sd30000;
    if (n == 0) return -16'sd10000;
    d = longint'(log2_fix(x)) - longint'(log2_fix(n));
    mag = (d < 0) ? -d : d;
    mag = (mag * 64'd744261118 + (64'd1 << 29)) >> 30;
    ln = (d < 0) ? -longint'(mag) : longint'(mag);
    den = 64'sd395000 * 64'sd16777216 + 64'sd29815 * ln;
    if (den <= 0) return 16'sd30000;
    num = 64'd29815 * 64'd395000 * 64'd16777216;
    tk = longint'((num + longint'(den) / 2) / longint'(den));
    t = tk - 27315;
    if (t < -10000) t = -10000;
    if (t > 30000) t = 30000;
    return 16'(t);
  endfunction

  function automatic reading_t convert_sample(input sample_t s);
    reading_t r;
    int unsigned vc, tc;
    vc = s.vcode;
    tc = s.tcode;
    r.vcode = s.vcode;
    r.tcode = s.tcode;
    r.stamp = s.stamp;
    r.pin_mv = '0;
    r.cell_mv = '0;
    r.v_ok = 1'b0;
    r.temp = '0;
    r.t_ok = 1'b0;
    if (vc <= ADC_FULL_SCALE) begin
      r.pin_mv = 12'((vc * 6540 + ADC_FULL_SCALE) / (2 * ADC_FULL_SCALE));
      r.cell_mv = 13'((vc * 9810 + ADC_FULL_SCALE) / (2 * ADC_FULL_SCALE));
      r.v_ok = 1'b1;
    end
    if (tc > ADC_FULL_SCALE) r.state = NTC_INVALID;
    else if (tc <= short_thr) r.state = NTC_SHORT;
    else if (tc >= open_thr) r.state = NTC_OPEN;
    else begin
      r.state = NTC_NORMAL;
      r.temp = beta_temp(tc, ADC_FULL_SCALE - tc);
      r.t_ok = 1'b1;
    end
    seq_count = seq_count + 1;
    if (seq_count == 0) seq_count = 1;
    r.seq = seq_count;
    return r;
  endfunction

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.voltage_code = '0;
    in_ch.thermistor_code = '0;
    in_ch.now_ms = '0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      // A transaction completes at this edge; predict it from the current thresholds.
      if (in_ch.valid && in_ch.ready) begin
        expected_readings.push_back(convert_sample(pending_samples.pop_front()));
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() > (in_ch.valid && in_ch.ready ? 0 : 0) &&
                     pending_samples.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.voltage_code <= pending_samples[0].vcode;
          in_ch.thermistor_code <= pending_samples[0].tcode;
          in_ch.now_ms <= pending_samples[0].stamp;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 150);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: the receiver stalls in phases of its own and checks every field.
  int stall_mode = 0;
  int stall_phase = 0;
  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    reading_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_readings.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          e = expected_readings.pop_front();
          if (out_ch.raw_voltage_code !== e.vcode) begin
            $error("raw_voltage_code exp %0d got %0d", e.vcode, out_ch.raw_voltage_code);
            errors++;
          end
          if (out_ch.raw_thermistor_code !== e.tcode) begin
            $error("raw_thermistor_code exp %0d got %0d", e.tcode, out_ch.raw_thermistor_code);
            errors++;
          end
          if (out_ch.pin_millivolts !== e.pin_mv) begin
            $error("pin_millivolts exp %0d got %0d", e.pin_mv, out_ch.pin_millivolts);
            errors++;
          end
          if (out_ch.cell_millivolts !== e.cell_mv) begin
            $error("cell_millivolts exp %0d got %0d", e.cell_mv, out_ch.cell_millivolts);
            errors++;
          end
          if (out_ch.voltage_ok !== e.v_ok) begin
            $error("voltage_ok exp %0d got %0d", e.v_ok, out_ch.voltage_ok);
            errors++;
          end
          if (out_ch.temperature_centi !== e.temp) begin
            $error("temperature_centi exp %0d got %0d", e.temp, out_ch.temperature_centi);
            errors++;
          end
          if (out_ch.temperature_ok !== e.t_ok) begin
            $error("temperature_ok exp %0d got %0d", e.t_ok, out_ch.temperature_ok);
            errors++;
          end
          if (out_ch.ntc_state !== e.state) begin
            $error("ntc_state exp %0d got %0d", e.state, out_ch.ntc_state);
            errors++;
          end
          if (out_ch.sequence_number !== e.seq) begin
            $error("sequence_number exp %0d got %0d", e.seq, out_ch.sequence_number);
            errors++;
          end
          if (out_ch.stamp_ms !== e.stamp) begin
            $error("stamp_ms exp %0d got %0d", e.stamp, out_ch.stamp_ms);
            errors++;
          end
        end
      end
      // Switch stall pattern every so often: none, periodic, random, long holds.
      if (stall_phase == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_phase = $urandom_range(50, 600);
      end else stall_phase--;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= (stall_phase % 7) < 3;
        2: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= ($urandom_range(0, 99) < 3) ? ~out_ch.ready : out_ch.ready;
      endcase
    end
  end

  task automatic add_sample(input logic [15:0] v, input logic [15:0] t, input logic [31:0] ms);
    sample_t s;
    s.vcode = v;
    s.tcode = t;
    s.stamp = ms;
    pending_samples.push_back(s);
  endtask

  // Waits for the block to drain, then writes one threshold register.
  task automatic write_threshold(input cfg_reg_t idx, input logic [11:0] value);
    while (pending_samples.size() != 0 || in_ch.valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SHORT_THRESHOLD) short_thr = value;
    else open_thr = value;
  endtask

  function automatic logic [15:0] random_code();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return 16'($urandom_range(0, 40));
    if (k == 2) return 16'($urandom_range(4050, 4200));
    return 16'($urandom_range(0, 4095));
  endfunction

  initial begin
    logic [11:0] shorts[4];
    logic [11:0] opens[4];
    shorts = '{12'd16, 12'd0, 12'd4095, 12'd1000};
    opens = '{12'd4079, 12'd4095, 12'd0, 12'd3000};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, each NTC class and the timestamp extremes.
    add_sample(16'd0, 16'd0, 32'd0);
    add_sample(16'd4095, 16'd4095, 32'hFFFF_FFFF);
    add_sample(16'd4096, 16'd4096, 32'h5555_5555);
    add_sample(16'hFFFF, 16'hFFFF, 32'hAAAA_AAAA);
    add_sample(16'd1, 16'd16, 32'd1);
    add_sample(16'd2048, 16'd17, 32'd2);
    add_sample(16'd2047, 16'd2048, 32'd3);
    add_sample(16'd1365, 16'd4078, 32'd4);
    add_sample(16'd3000, 16'd4079, 32'd5);
    add_sample(16'd100, 16'd1, 32'd6);
    add_sample(16'd4094, 16'd4094, 32'd7);
    // Thresholds that let codes 1 and 4094 through as normal; 0 and 4095 stay short and open.
    write_threshold(CFG_SHORT_THRESHOLD, 12'd0);
    write_threshold(CFG_OPEN_THRESHOLD, 12'd4095);
    add_sample(16'd10, 16'd1, 32'd8);
    add_sample(16'd20, 16'd4094, 32'd9);
    add_sample(16'd30, 16'd4095, 32'd10);
    add_sample(16'd40, 16'd0, 32'd11);
    add_sample(16'd50, 16'd60, 32'd12);
    add_sample(16'd60, 16'd4060, 32'd13);
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(CFG_SHORT_THRESHOLD, shorts[ph]);
      write_threshold(CFG_OPEN_THRESHOLD, opens[ph]);
      for (int i = 0; i < 335; i++) add_sample(random_code(), random_code(), $urandom);
    end
    while (pending_samples.size() != 0 || in_ch.valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Slowest run: ~1400 items with gaps and stalls, about 2.5 ms, well under this.
  initial begin
    #16_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/bntc_pkg.sv
rtl/bntc_in_if.sv
rtl/bntc_out_if.sv
rtl/bntc_fifo.sv
rtl/bntc_front.sv
rtl/bntc_log2.sv
rtl/bntc_div.sv
rtl/bntc_back.sv
rtl/battery_adc_ntc_sensor_convert_top.sv
dv/battery_adc_ntc_sensor_convert_top_test.sv
